// File: design/tmvg_pkg.sv
// Shared types, constants and arithmetic helpers of the torus vertex generator.
package tmvg_pkg;

    localparam int MAX_SEGMENTS = 256;

    localparam int CNT_W   = 9;
    localparam int LEN_W   = 23;
    localparam int ANG_W   = 16;
    localparam int SWP_W   = 17;
    localparam int POS_W   = 26;
    localparam int NRM_W   = 16;
    localparam int TEX_W   = 17;
    localparam int IDX_W   = 17;
    localparam int DIV_W   = 25;
    localparam int DIV_LAT = DIV_W + 1;
    localparam int SIN_LAT = 8;
    localparam int Q_W     = 31;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 23;

    localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd16384;

    // Q30 Taylor coefficients of sin(pi/2 x)
    localparam logic [Q_W-1:0] SIN_C1 = 31'd1686629713;
    localparam logic [Q_W-1:0] SIN_C3 = 31'd693598668;
    localparam logic [Q_W-1:0] SIN_C5 = 31'd85569306;
    localparam logic [Q_W-1:0] SIN_C7 = 31'd5026995;
    localparam logic [Q_W-1:0] SIN_C9 = 31'd172272;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_RADIUS   = 4'd0,
        CFG_TUBE_RADIUS   = 4'd1,
        CFG_RADIAL_COUNT  = 4'd2,
        CFG_TUBULAR_COUNT = 4'd3,
        CFG_RADIAL_BEGIN  = 4'd4,
        CFG_RADIAL_SWEEP  = 4'd5,
        CFG_TUBULAR_BEGIN = 4'd6,
        CFG_TUBULAR_SWEEP = 4'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [LEN_W-1:0] ring_radius;
        logic [LEN_W-1:0] tube_radius;
        logic [CNT_W-1:0] radial_count;
        logic [CNT_W-1:0] tubular_count;
        logic [ANG_W-1:0] radial_begin;
        logic [SWP_W-1:0] radial_sweep;
        logic [ANG_W-1:0] tubular_begin;
        logic [SWP_W-1:0] tubular_sweep;
    } t_cfg;

    // Index data that bypasses the dividers
    typedef struct packed {
        logic             quad;
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic             cull;
    } t_tag;

    // Classified item handed from front to back
    typedef struct packed {
        logic [DIV_W-1:0] num_u;
        logic [DIV_W-1:0] num_v;
        logic [DIV_W-1:0] num_s;
        logic [DIV_W-1:0] num_t;
        logic [CNT_W-1:0] den_r;
        logic [CNT_W-1:0] den_t;
        t_tag             tag;
    } t_work;

    typedef struct packed {
        logic [TEX_W-1:0] tex_s;
        logic [TEX_W-1:0] tex_t;
        t_tag             tag;
    } t_side;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > CNT_W'(MAX_SEGMENTS)) begin
            r = CNT_W'(MAX_SEGMENTS);
        end else begin
            r = c;
        end
        return r;
    endfunction

    // a * c / 2^15, rounded half away from zero
    function automatic logic signed [POS_W-1:0] mul_q15(input logic signed [POS_W-1:0] a,
                                                        input logic signed [NRM_W-1:0] c);
        logic                     neg;
        logic [POS_W-1:0]         ma;
        logic [NRM_W-1:0]         mc;
        logic [POS_W+NRM_W-1:0]   prod;
        logic [POS_W+NRM_W-1:0]   rnd;
        logic signed [POS_W-1:0]  m;
        neg  = a[POS_W-1] ^ c[NRM_W-1];
        ma   = a[POS_W-1] ? POS_W'(-a) : POS_W'(a);
        mc   = c[NRM_W-1] ? NRM_W'(-c) : NRM_W'(c);
        prod = {{NRM_W{1'b0}}, ma} * {{POS_W{1'b0}}, mc};
        rnd  = (prod + (POS_W+NRM_W)'(16384)) >> 15;
        m    = $signed(rnd[POS_W-1:0]);
        return neg ? -m : m;
    endfunction

endpackage

// File: design/tmvg_front.sv
// Front end: takes grid points, clamps them and forms dividends and quad indices.
module tmvg_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [tmvg_pkg::CNT_W-1:0] i_grid_row,
    input  logic [tmvg_pkg::CNT_W-1:0] i_grid_col,
    input  tmvg_pkg::t_cfg          i_cfg,
    input  logic                    i_full,
    output logic                    o_busy,
    output logic                    o_push,
    output tmvg_pkg::t_work         o_work
);
    import tmvg_pkg::*;

    logic             r_vld;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] r_col;

    logic [CNT_W-1:0] n_r;
    logic [CNT_W-1:0] n_t;
    logic [CNT_W-1:0] n_j;
    logic [CNT_W-1:0] n_i;
    logic [CNT_W:0]   n_t1;
    logic [18:0]      n_tj;
    logic [18:0]      n_ca;
    logic [18:0]      n_cb;
    logic             n_quad;

    assign o_busy = r_vld & i_full;
    assign o_push = r_vld & ~i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_row <= i_grid_row;
            r_col <= i_grid_col;
        end
    end

    always_comb begin
        n_r    = eff_count(i_cfg.radial_count);
        n_t    = eff_count(i_cfg.tubular_count);
        n_j    = (r_row > n_r) ? n_r : r_row;
        n_i    = (r_col > n_t) ? n_t : r_col;
        n_t1   = {1'b0, n_t} + (CNT_W+1)'(1);
        n_tj   = 19'(n_t1) * 19'(n_j);
        n_ca   = n_tj + 19'(n_i) - 19'd1;
        n_cb   = n_ca - 19'(n_t1);
        n_quad = (n_i != '0) && (n_j != '0);

        o_work.num_u = DIV_W'(n_j) * DIV_W'(i_cfg.radial_sweep) + DIV_W'(n_r >> 1);
        o_work.num_v = DIV_W'(n_i) * DIV_W'(i_cfg.tubular_sweep) + DIV_W'(n_t >> 1);
        o_work.num_s = {n_i, 16'b0} + DIV_W'(n_t >> 1);
        o_work.num_t = {n_j, 16'b0} + DIV_W'(n_r >> 1);
        o_work.den_r = n_r;
        o_work.den_t = n_t;
        o_work.tag.quad     = n_quad;
        o_work.tag.corner_a = n_quad ? n_ca[IDX_W-1:0] : '0;
        o_work.tag.corner_b = n_quad ? n_cb[IDX_W-1:0] : '0;
        o_work.tag.cull     = (i_cfg.tubular_sweep == 17'd65536) &&
                              (i_cfg.radial_sweep == 17'd32768);
    end

endmodule

// File: design/tmvg_queue.sv
// Two-entry queue between front and back end.
module tmvg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmvg_pkg::t_work i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tmvg_pkg::t_work o_data
);
    import tmvg_pkg::*;

    t_work      r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       n_do_pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_data   = r_mem[r_rd_ptr];
    assign n_do_pop = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (n_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(n_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/tmvg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tmvg_div (
    input  logic                       i_clk,
    input  logic [tmvg_pkg::DIV_W-1:0] i_num,
    input  logic [tmvg_pkg::CNT_W-1:0] i_den,
    output logic [tmvg_pkg::DIV_W-1:0] o_quo
);
    import tmvg_pkg::*;

    logic [CNT_W-1:0] r_rem [0:DIV_W-1];
    logic [DIV_W-1:0] r_num [0:DIV_W-1];
    logic [CNT_W-1:0] r_den [0:DIV_W-1];
    logic [DIV_W-1:0] r_quo [0:DIV_W];

    logic [CNT_W:0]   n_trial [0:DIV_W-1];
    logic [CNT_W:0]   n_diff  [0:DIV_W-1];
    logic             n_ge    [0:DIV_W-1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        assign n_trial[k] = {r_rem[k], r_num[k][DIV_W-1]};
        assign n_diff[k]  = n_trial[k] - {1'b0, r_den[k]};
        assign n_ge[k]    = (n_trial[k] >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            r_quo[k+1] <= {r_quo[k][DIV_W-2:0], n_ge[k]};
        end

        if (k < DIV_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= n_ge[k] ? n_diff[k][CNT_W-1:0] : n_trial[k][CNT_W-1:0];
                r_num[k+1] <= {r_num[k][DIV_W-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_quo = r_quo[DIV_W];

endmodule

// File: design/tmvg_sine.sv
// Pipelined Q15 sine of a 16-bit angle, ninth-order polynomial on a quarter wave.
module tmvg_sine (
    input  logic                              i_clk,
    input  logic        [tmvg_pkg::ANG_W-1:0] i_angle,
    output logic signed [tmvg_pkg::NRM_W-1:0] o_sin
);
    import tmvg_pkg::*;

    logic [14:0]      n_fold;
    logic [2*Q_W-1:0] n_xx;
    logic [2*Q_W-1:0] n_zp_c;
    logic [2*Q_W-1:0] n_zp_d;
    logic [2*Q_W-1:0] n_zp_e;
    logic [2*Q_W-1:0] n_zp_f;
    logic [2*Q_W-1:0] n_xp;
    logic [Q_W+1:0]   n_sum;
    logic [16:0]      n_rnd;
    logic [14:0]      n_mag;

    logic [Q_W-1:0] r_a_x, r_b_x, r_c_x, r_d_x, r_e_x, r_f_x;
    logic [Q_W-1:0] r_b_z, r_c_z, r_d_z, r_e_z;
    logic [Q_W-1:0] r_c_p, r_d_p, r_e_p, r_f_p;
    logic [Q_W-1:0] r_g_s;
    logic           r_a_neg, r_b_neg, r_c_neg, r_d_neg, r_e_neg, r_f_neg, r_g_neg;
    logic signed [NRM_W-1:0] r_h_out;

    always_comb begin
        n_fold = i_angle[14] ? (15'd16384 - {1'b0, i_angle[13:0]}) : {1'b0, i_angle[13:0]};
        n_xx   = (2*Q_W)'(r_a_x) * (2*Q_W)'(r_a_x);
        n_zp_c = (2*Q_W)'(r_b_z) * (2*Q_W)'(SIN_C9);
        n_zp_d = (2*Q_W)'(r_c_z) * (2*Q_W)'(r_c_p);
        n_zp_e = (2*Q_W)'(r_d_z) * (2*Q_W)'(r_d_p);
        n_zp_f = (2*Q_W)'(r_e_z) * (2*Q_W)'(r_e_p);
        n_xp   = (2*Q_W)'(r_f_x) * (2*Q_W)'(r_f_p);
        n_sum  = (Q_W+2)'(r_g_s) + (Q_W+2)'(16384);
        n_rnd  = n_sum[31:15];
        n_mag  = (n_rnd > 17'd32767) ? 15'h7FFF : n_rnd[14:0];
    end

    always_ff @(posedge i_clk) begin
        r_a_x   <= {n_fold, 16'b0};
        r_a_neg <= i_angle[15];

        r_b_x   <= r_a_x;
        r_b_z   <= n_xx[60:30];
        r_b_neg <= r_a_neg;

        r_c_x   <= r_b_x;
        r_c_z   <= r_b_z;
        r_c_p   <= SIN_C7 - n_zp_c[60:30];
        r_c_neg <= r_b_neg;

        r_d_x   <= r_c_x;
        r_d_z   <= r_c_z;
        r_d_p   <= SIN_C5 - n_zp_d[60:30];
        r_d_neg <= r_c_neg;

        r_e_x   <= r_d_x;
        r_e_z   <= r_d_z;
        r_e_p   <= SIN_C3 - n_zp_e[60:30];
        r_e_neg <= r_d_neg;

        r_f_x   <= r_e_x;
        r_f_p   <= SIN_C1 - n_zp_f[60:30];
        r_f_neg <= r_e_neg;

        r_g_s   <= n_xp[60:30];
        r_g_neg <= r_f_neg;

        r_h_out <= r_g_neg ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
    end

    assign o_sin = r_h_out;

endmodule

// File: design/tmvg_back.sv
// Back end: angle division, sine/cosine and the position and normal products.
module tmvg_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  tmvg_pkg::t_work                   i_work,
    input  tmvg_pkg::t_cfg                    i_cfg,
    output logic                              o_strobe,
    output logic signed [tmvg_pkg::POS_W-1:0] o_pos_x,
    output logic signed [tmvg_pkg::POS_W-1:0] o_pos_y,
    output logic signed [tmvg_pkg::POS_W-1:0] o_pos_z,
    output logic signed [tmvg_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [tmvg_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [tmvg_pkg::NRM_W-1:0] o_normal_z,
    output logic        [tmvg_pkg::TEX_W-1:0] o_tex_s,
    output logic        [tmvg_pkg::TEX_W-1:0] o_tex_t,
    output logic                              o_quad_valid,
    output logic        [tmvg_pkg::IDX_W-1:0] o_corner_a,
    output logic        [tmvg_pkg::IDX_W-1:0] o_corner_b,
    output logic                              o_culling_on
);
    import tmvg_pkg::*;

    localparam int TOTAL_LAT = DIV_LAT + 1 + SIN_LAT + 3;

    logic [TOTAL_LAT-1:0] r_vld;
    t_tag  r_tag_d [0:DIV_LAT-1];
    t_side r_side_d [0:SIN_LAT-1];

    logic [DIV_W-1:0] n_quo_u, n_quo_v, n_quo_s, n_quo_t;

    logic [ANG_W-1:0] r_u, r_uc, r_v, r_vc;
    t_side            r_b0_side;

    logic signed [NRM_W-1:0] n_su, n_cu, n_sv, n_cv;

    logic signed [POS_W-1:0] r_p1_tcv, r_p1_pz, r_p1_nx, r_p1_ny;
    logic signed [NRM_W-1:0] r_p1_cu, r_p1_su, r_p1_nz;
    t_side                   r_p1_side;

    logic signed [POS_W-1:0] r_p2_w, r_p2_pz;
    logic signed [NRM_W-1:0] r_p2_cu, r_p2_su, r_p2_nx, r_p2_ny, r_p2_nz;
    t_side                   r_p2_side;

    logic signed [POS_W-1:0] n_tube;
    logic signed [POS_W-1:0] n_ring;
    logic signed [POS_W-1:0] n_cv_ext;

    assign n_tube   = $signed({3'b0, i_cfg.tube_radius});
    assign n_ring   = $signed({3'b0, i_cfg.ring_radius});
    assign n_cv_ext = POS_W'(n_cv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_valid};
        end
    end

    tmvg_div u_div_u (.i_clk(i_clk), .i_num(i_work.num_u), .i_den(i_work.den_r), .o_quo(n_quo_u));
    tmvg_div u_div_v (.i_clk(i_clk), .i_num(i_work.num_v), .i_den(i_work.den_t), .o_quo(n_quo_v));
    tmvg_div u_div_s (.i_clk(i_clk), .i_num(i_work.num_s), .i_den(i_work.den_t), .o_quo(n_quo_s));
    tmvg_div u_div_t (.i_clk(i_clk), .i_num(i_work.num_t), .i_den(i_work.den_r), .o_quo(n_quo_t));

    // tag rides alongside the dividers
    always_ff @(posedge i_clk) begin
        r_tag_d[0] <= i_work.tag;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_tag_d[k] <= r_tag_d[k-1];
        end
    end

    // angles and texture coordinates
    always_ff @(posedge i_clk) begin
        r_u  <= i_cfg.radial_begin + n_quo_u[ANG_W-1:0];
        r_uc <= i_cfg.radial_begin + n_quo_u[ANG_W-1:0] + QUARTER_TURN;
        r_v  <= i_cfg.tubular_begin + n_quo_v[ANG_W-1:0];
        r_vc <= i_cfg.tubular_begin + n_quo_v[ANG_W-1:0] + QUARTER_TURN;
        r_b0_side.tex_s <= n_quo_s[TEX_W-1:0];
        r_b0_side.tex_t <= n_quo_t[TEX_W-1:0];
        r_b0_side.tag   <= r_tag_d[DIV_LAT-1];
    end

    tmvg_sine u_sin_u (.i_clk(i_clk), .i_angle(r_u),  .o_sin(n_su));
    tmvg_sine u_cos_u (.i_clk(i_clk), .i_angle(r_uc), .o_sin(n_cu));
    tmvg_sine u_sin_v (.i_clk(i_clk), .i_angle(r_v),  .o_sin(n_sv));
    tmvg_sine u_cos_v (.i_clk(i_clk), .i_angle(r_vc), .o_sin(n_cv));

    always_ff @(posedge i_clk) begin
        r_side_d[0] <= r_b0_side;
        for (int k = 1; k < SIN_LAT; k++) begin
            r_side_d[k] <= r_side_d[k-1];
        end
    end

    // first products
    always_ff @(posedge i_clk) begin
        r_p1_tcv  <= mul_q15(n_tube, n_cv);
        r_p1_pz   <= mul_q15(n_tube, n_sv);
        r_p1_nx   <= mul_q15(n_cv_ext, n_cu);
        r_p1_ny   <= mul_q15(n_cv_ext, n_su);
        r_p1_nz   <= n_sv;
        r_p1_cu   <= n_cu;
        r_p1_su   <= n_su;
        r_p1_side <= r_side_d[SIN_LAT-1];
    end

    // ring plus tube offset
    always_ff @(posedge i_clk) begin
        r_p2_w    <= n_ring + r_p1_tcv;
        r_p2_pz   <= r_p1_pz;
        r_p2_nx   <= r_p1_nx[NRM_W-1:0];
        r_p2_ny   <= r_p1_ny[NRM_W-1:0];
        r_p2_nz   <= r_p1_nz;
        r_p2_cu   <= r_p1_cu;
        r_p2_su   <= r_p1_su;
        r_p2_side <= r_p1_side;
    end

    always_ff @(posedge i_clk) begin
        o_pos_x      <= mul_q15(r_p2_w, r_p2_cu);
        o_pos_y      <= mul_q15(r_p2_w, r_p2_su);
        o_pos_z      <= r_p2_pz;
        o_normal_x   <= r_p2_nx;
        o_normal_y   <= r_p2_ny;
        o_normal_z   <= r_p2_nz;
        o_tex_s      <= r_p2_side.tex_s;
        o_tex_t      <= r_p2_side.tex_t;
        o_quad_valid <= r_p2_side.tag.quad;
        o_corner_a   <= r_p2_side.tag.corner_a;
        o_corner_b   <= r_p2_side.tag.corner_b;
        o_culling_on <= r_p2_side.tag.cull;
    end

    assign o_strobe = r_vld[TOTAL_LAT-1];

endmodule

// File: design/torus_mesh_vertex_generator_core.sv
// Top level of the torus mesh vertex generator: config registers, front, queue, back.
//
//  Channel   Signals                              Transfer when
//  --------  -----------------------------------  ----------------------------
//  command   start, busy, i_grid_row/col          start high, busy low
//  result    o_result_strobe, o_pos_*, o_normal_*  strobe high (one cycle)
//            o_tex_*, o_quad_valid, o_corner_*,
//            o_culling_on
//  config    i_cfg_valid, o_cfg_ready,            valid and ready high
//            i_cfg_index, i_cfg_data
//
// One grid point per clock, sustained. The path from the accepting edge to the
// strobe runs through the front register, queue, 26-stage bit-per-cycle dividers
// for u, v and the texture ratios, 8-stage polynomial sine units and three
// product stages. Reset (synchronous, active low) loads the register defaults
// and empties the pipe. The result side cannot stall, so the back end drains
// the queue every cycle; busy rises only if the queue were ever full.
module torus_mesh_vertex_generator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [tmvg_pkg::CNT_W-1:0]     i_grid_row,
    input  logic        [tmvg_pkg::CNT_W-1:0]     i_grid_col,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [tmvg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [tmvg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                  o_result_strobe,
    output logic signed [tmvg_pkg::POS_W-1:0]     o_pos_x,
    output logic signed [tmvg_pkg::POS_W-1:0]     o_pos_y,
    output logic signed [tmvg_pkg::POS_W-1:0]     o_pos_z,
    output logic signed [tmvg_pkg::NRM_W-1:0]     o_normal_x,
    output logic signed [tmvg_pkg::NRM_W-1:0]     o_normal_y,
    output logic signed [tmvg_pkg::NRM_W-1:0]     o_normal_z,
    output logic        [tmvg_pkg::TEX_W-1:0]     o_tex_s,
    output logic        [tmvg_pkg::TEX_W-1:0]     o_tex_t,
    output logic                                  o_quad_valid,
    output logic        [tmvg_pkg::IDX_W-1:0]     o_corner_a,
    output logic        [tmvg_pkg::IDX_W-1:0]     o_corner_b,
    output logic                                  o_culling_on
);
    import tmvg_pkg::*;

    t_cfg  r_cfg;
    logic  n_push;
    logic  n_full;
    logic  n_q_valid;
    t_work n_front_work;
    t_work n_q_work;

    // config is always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_radius   <= 23'd65536;
            r_cfg.tube_radius   <= 23'd26214;
            r_cfg.radial_count  <= 9'd8;
            r_cfg.tubular_count <= 9'd6;
            r_cfg.radial_begin  <= 16'd0;
            r_cfg.radial_sweep  <= 17'd32768;
            r_cfg.tubular_begin <= 16'd0;
            r_cfg.tubular_sweep <= 17'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RING_RADIUS:   r_cfg.ring_radius   <= i_cfg_data[LEN_W-1:0];
                CFG_TUBE_RADIUS:   r_cfg.tube_radius   <= i_cfg_data[LEN_W-1:0];
                CFG_RADIAL_COUNT:  r_cfg.radial_count  <= i_cfg_data[CNT_W-1:0];
                CFG_TUBULAR_COUNT: r_cfg.tubular_count <= i_cfg_data[CNT_W-1:0];
                CFG_RADIAL_BEGIN:  r_cfg.radial_begin  <= i_cfg_data[ANG_W-1:0];
                CFG_RADIAL_SWEEP:  r_cfg.radial_sweep  <= i_cfg_data[SWP_W-1:0];
                CFG_TUBULAR_BEGIN: r_cfg.tubular_begin <= i_cfg_data[ANG_W-1:0];
                CFG_TUBULAR_SWEEP: r_cfg.tubular_sweep <= i_cfg_data[SWP_W-1:0];
                default: ; // unknown index, dropped
            endcase
        end
    end

    // clamp, dividends and quad indices
    tmvg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_grid_row (i_grid_row),
        .i_grid_col (i_grid_col),
        .i_cfg      (r_cfg),
        .i_full     (n_full),
        .o_busy     (busy),
        .o_push     (n_push),
        .o_work     (n_front_work)
    );

    tmvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_data  (n_front_work),
        .i_pop   (n_q_valid),
        .o_full  (n_full),
        .o_valid (n_q_valid),
        .o_data  (n_q_work)
    );

    // back end takes the queue head every cycle
    tmvg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (n_q_valid),
        .i_work       (n_q_work),
        .i_cfg        (r_cfg),
        .o_strobe     (o_result_strobe),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_tex_s      (o_tex_s),
        .o_tex_t      (o_tex_t),
        .o_quad_valid (o_quad_valid),
        .o_corner_a   (o_corner_a),
        .o_corner_b   (o_corner_b),
        .o_culling_on (o_culling_on)
    );

endmodule
